@@ design/pwq_pkg.sv @@
// ---------------------------------------------------------------------------
// pwq_pkg: shared types and a helper for the priority wait queue lists
// Entry and token layouts for the cell chain, request/result payloads,
// operation codes and the list index wrap.
// ---------------------------------------------------------------------------
package pwq_pkg;

  // default number of waiter entries (cells in the chain)
  localparam int NODES_DEF = 32;
  // number of wait lists
  localparam int LISTS = 8;

  localparam int ITEM_W = 5;
  localparam int LIST_W = 3;
  localparam int PRIO_W = 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIRST  = 2'd2,
    OP_LAST   = 2'd3
  } op_t;

  // request payload
  typedef struct packed {
    logic [1:0]        opcode;
    logic [LIST_W-1:0] list_sel;
    logic [ITEM_W-1:0] item;
    logic              kind;
    logic [PRIO_W-1:0] prio;
  } req_t;

  // result payload
  typedef struct packed {
    logic [ITEM_W-1:0] item_out;
    logic              found;
  } res_t;

  // one waiter held in a cell
  typedef struct packed {
    logic              valid;
    logic [LIST_W-1:0] list;
    logic [PRIO_W-1:0] key;
    logic              kind;
    logic [ITEM_W-1:0] item;
  } entry_t;

  // operation token walking down the chain
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic              act;      // operation takes effect
    logic              shift;    // edit point passed, cells now shift
    logic [LIST_W-1:0] list;
    entry_t            ent;      // entry to place, or carried displaced entry
    logic              found;
    logic [ITEM_W-1:0] res_item;
  } token_t;

  // list_sel modulo LISTS by repeated subtraction (value is below 8)
  function automatic logic [LIST_W-1:0] list_wrap(input logic [LIST_W-1:0] sel);
    int v;
    v = int'(sel);
    for (int k = 0; k < 8; k++) begin
      if (v >= LISTS) begin
        v = v - LISTS;
      end
    end
    return LIST_W'(v);
  endfunction

endpackage

@@ design/priority_wait_queue_lists.sv @@
// ---------------------------------------------------------------------------
// priority_wait_queue_lists: priority ordered lock wait lists, shared table
// A start is accepted only while busy is low; the token then passes the launch
// register and every cell register before the done strobe. busy is high
// meanwhile, so one request is in flight; the token steps one cell per cycle.
// Reset empties every list at once; the receiver cannot stall done.
// ---------------------------------------------------------------------------
module priority_wait_queue_lists
  import pwq_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output res_t result
);

  entry_t ents [NODES];
  token_t toks [NODES+1];

  pwq_ctrl #(
    .NODES(NODES)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req     (req),
    .tok_end (toks[NODES]),
    .busy    (busy),
    .launch  (toks[0]),
    .done    (done),
    .result  (result)
  );

  // chain of entry cells
  for (genvar i = 0; i < NODES; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;

    if (i == 0) begin : g_first
      assign prev_e = '0;
    end else begin : g_mid_prev
      assign prev_e = ents[i-1];
    end

    if (i == NODES-1) begin : g_last
      assign next_e = '0;
    end else begin : g_mid_next
      assign next_e = ents[i+1];
    end

    pwq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   (toks[i]),
      .prev_ent (prev_e),
      .next_ent (next_e),
      .ent      (ents[i]),
      .tok_out  (toks[i+1])
    );
  end

endmodule

@@ design/pwq_cell.sv @@
// ---------------------------------------------------------------------------
// pwq_cell: one slot of the sorted waiter chain
// Holds one entry. Entries sit packed from cell 0, ordered by list and then
// by list order. The token is processed here and handed to the next cell.
// ---------------------------------------------------------------------------
module pwq_cell
  import pwq_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  token_t tok_in,
  input  entry_t prev_ent,
  input  entry_t next_ent,
  output entry_t ent,
  output token_t tok_out
);

  entry_t ent_next;
  token_t tok_next;
  logic   place;
  logic   hit;
  logic   passes;

  // insert walks past higher keys and equal-key writers
  always_comb begin
    passes = (ent.key > tok_in.ent.key) ||
             ((ent.key == tok_in.ent.key) && ent.kind);
    place  = !ent.valid || (ent.list > tok_in.list) ||
             ((ent.list == tok_in.list) && !passes);
  end

  // unlink targets: named item, head of list, tail of list
  always_comb begin
    hit = 1'b0;
    unique case (tok_in.op)
      OP_INSERT: hit = 1'b0;
      OP_REMOVE: hit = ent.valid && (ent.item == tok_in.ent.item);
      OP_FIRST:  hit = ent.valid && (ent.list == tok_in.list) &&
                       !(prev_ent.valid && (prev_ent.list == tok_in.list));
      OP_LAST:   hit = ent.valid && (ent.list == tok_in.list) &&
                       !(next_ent.valid && (next_ent.list == tok_in.list));
    endcase
  end

  // cell update and token forward
  always_comb begin
    ent_next = ent;
    tok_next = tok_in;
    if (tok_in.valid && tok_in.act) begin
      if (tok_in.op == OP_INSERT) begin
        if (tok_in.shift || place) begin
          ent_next       = tok_in.ent;
          tok_next.ent   = ent;
          tok_next.shift = 1'b1;
        end
      end else begin
        if (tok_in.shift) begin
          ent_next = next_ent;
        end else if (hit) begin
          ent_next          = next_ent;
          tok_next.shift    = 1'b1;
          tok_next.found    = 1'b1;
          tok_next.res_item = ent.item;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid     <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      ent     <= ent_next;
      tok_out <= tok_next;
    end
  end

endmodule

@@ design/pwq_ctrl.sv @@
// ---------------------------------------------------------------------------
// pwq_ctrl: request intake, membership bits and result register
// Launches one token per request into the chain and reports the result
// when the token leaves the last cell.
// ---------------------------------------------------------------------------
module pwq_ctrl
  import pwq_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  req_t   req,
  input  token_t tok_end,
  output logic   busy,
  output token_t launch,
  output logic   done,
  output res_t   result
);

  localparam int IW = $clog2(NODES);

  logic [NODES-1:0] on_bits;
  logic [IW-1:0]    item_idx;
  logic [IW-1:0]    end_idx;
  logic             in_range;
  logic             accept;
  logic             act;
  logic             is_take;
  op_t              op;
  token_t           launch_next;

  assign accept   = start && !busy;
  assign op       = op_t'(req.opcode);
  assign in_range = 32'(req.item) < NODES;
  assign item_idx = IW'(req.item);
  assign end_idx  = IW'(tok_end.res_item);
  assign is_take  = (op == OP_FIRST) || (op == OP_LAST);

  // does the request take effect
  always_comb begin
    act = 1'b0;
    unique case (op)
      OP_INSERT: act = in_range && !on_bits[item_idx];
      OP_REMOVE: act = in_range && on_bits[item_idx];
      OP_FIRST:  act = 1'b1;
      OP_LAST:   act = 1'b1;
    endcase
  end

  // token built from the request
  always_comb begin
    launch_next.valid     = accept;
    launch_next.op        = op;
    launch_next.act       = act;
    launch_next.shift     = 1'b0;
    launch_next.list      = list_wrap(req.list_sel);
    launch_next.ent.valid = 1'b1;
    launch_next.ent.list  = list_wrap(req.list_sel);
    launch_next.ent.key   = req.prio;
    launch_next.ent.kind  = req.kind;
    launch_next.ent.item  = req.item;
    launch_next.found     = is_take ? 1'b0 : act;
    launch_next.res_item  = is_take ? '0 : req.item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      done         <= 1'b0;
      launch.valid <= 1'b0;
      on_bits      <= '0;
    end else begin
      launch <= launch_next;
      done   <= 1'b0;
      if (accept) begin
        busy <= 1'b1;
        if ((op == OP_INSERT) && act) begin
          on_bits[item_idx] <= 1'b1;
        end
        if ((op == OP_REMOVE) && act) begin
          on_bits[item_idx] <= 1'b0;
        end
      end
      // token leaves the chain: report and retire
      if (tok_end.valid) begin
        busy            <= 1'b0;
        done            <= 1'b1;
        result.item_out <= tok_end.res_item;
        result.found    <= tok_end.found;
        if ((tok_end.op == OP_FIRST || tok_end.op == OP_LAST) && tok_end.found) begin
          on_bits[end_idx] <= 1'b0;
        end
      end
    end
  end

endmodule
